// ===== rtl/rsub_pkg.sv =====
// ----------------------------------------------------------------------------
// Rectangle subtract package
// Shared types and constants for the rectangle subtract unit.
// ----------------------------------------------------------------------------
package rsub_pkg;

    // One bit for each strip that survives the subtraction, in emission order.
    typedef struct packed {
        logic above;
        logic below;
        logic left;
        logic right;
    } t_piece_sel;

    localparam int SEL_BITS   = 4;
    localparam int INDEX_BITS = 2;

    // Number of coordinates carried per queued job.
    localparam int JOB_COORDS = 8;

    // Occupancy state of the job queue, reported to the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

// ===== rtl/rsub_front.sv =====
// ----------------------------------------------------------------------------
// Rectangle subtract front part
// Accepts a box and a hole, classifies the overlap and builds a queue job.
// ----------------------------------------------------------------------------
module rsub_front
    import rsub_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [COORD_BITS-1:0]          i_box_x0,
    input  logic signed [COORD_BITS-1:0]          i_box_y0,
    input  logic signed [COORD_BITS-1:0]          i_box_x1,
    input  logic signed [COORD_BITS-1:0]          i_box_y1,
    input  logic signed [COORD_BITS-1:0]          i_hole_x0,
    input  logic signed [COORD_BITS-1:0]          i_hole_y0,
    input  logic signed [COORD_BITS-1:0]          i_hole_x1,
    input  logic signed [COORD_BITS-1:0]          i_hole_y1,
    input  t_queue_status                         i_q_status,
    output logic                                  o_push,
    output logic [SEL_BITS+JOB_COORDS*COORD_BITS-1:0] o_job
);

    logic                         box_empty;
    logic                         disjoint;
    t_piece_sel                   sel;
    logic signed [COORD_BITS-1:0] row_lo;
    logic signed [COORD_BITS-1:0] row_hi;

    // Classify the pair and choose the rows that bound the side strips.
    always_comb begin
        box_empty = (i_box_y0 >= i_box_y1) || (i_box_x0 >= i_box_x1);
        disjoint  = (i_hole_y0 >= i_hole_y1) || (i_hole_x0 >= i_hole_x1) ||
                    (i_hole_y0 >= i_box_y1)  || (i_hole_y1 <= i_box_y0)  ||
                    (i_hole_x0 >= i_box_x1)  || (i_hole_x1 <= i_box_x0);
        sel    = '0;
        row_lo = i_box_y0;
        row_hi = i_box_y1;
        if (box_empty) begin
            sel = '0;
        end else if (disjoint) begin
            // The whole box goes out as an upper strip ending at the box bottom.
            sel.above = 1'b1;
            row_lo    = i_box_y1;
        end else begin
            sel.above = (i_hole_y0 > i_box_y0);
            sel.below = (i_hole_y1 < i_box_y1);
            sel.left  = (i_hole_x0 > i_box_x0);
            sel.right = (i_hole_x1 < i_box_x1);
            if (sel.above) begin
                row_lo = i_hole_y0;
            end
            if (sel.below) begin
                row_hi = i_hole_y1;
            end
        end
    end

    // An item is taken whenever the queue has room; items with no pieces vanish here.
    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full && (sel != '0);
    assign o_job   = {sel, i_box_x0, i_box_y0, i_box_x1, i_box_y1,
                      i_hole_x0, i_hole_x1, row_lo, row_hi};

endmodule

// ===== rtl/rsub_queue.sv =====
// ----------------------------------------------------------------------------
// Rectangle subtract job queue
// Small first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module rsub_queue
    import rsub_pkg::*;
#(
    parameter int WIDTH = 132,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_queue_status    o_status
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_BITS'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ===== rtl/rsub_back.sv =====
// ----------------------------------------------------------------------------
// Rectangle subtract back part
// Walks each job's strips; one piece per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module rsub_back
    import rsub_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  t_queue_status                             i_q_status,
    input  logic [SEL_BITS+JOB_COORDS*COORD_BITS-1:0] i_job,
    output logic                                      o_pop,
    output logic                                      o_busy,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic signed [COORD_BITS-1:0]              o_piece_x0,
    output logic signed [COORD_BITS-1:0]              o_piece_y0,
    output logic signed [COORD_BITS-1:0]              o_piece_x1,
    output logic signed [COORD_BITS-1:0]              o_piece_y1,
    output logic [INDEX_BITS-1:0]                     o_piece_index,
    output logic                                      o_last_piece
);

    localparam int CW = JOB_COORDS * COORD_BITS;

    // Current job, held while it still has strips to emit.
    logic                   r_busy;
    t_piece_sel             r_sel;
    logic [INDEX_BITS-1:0]  r_index;
    logic [CW-1:0]          r_coords;

    // Output register.
    logic                          r_out_valid;
    logic signed [COORD_BITS-1:0]  r_x0, r_y0, r_x1, r_y1;
    logic [INDEX_BITS-1:0]         r_out_index;
    logic                          r_out_last;

    t_piece_sel                   src_sel;
    t_piece_sel                   rem_sel;
    logic [CW-1:0]                src_coords;
    logic [INDEX_BITS-1:0]        src_index;
    logic signed [COORD_BITS-1:0] bx0, by0, bx1, by1, hx0, hx1, row_lo, row_hi;
    logic signed [COORD_BITS-1:0] px0, py0, px1, py1;
    logic                         can_load;
    logic                         fire;

    // Source is the held job, or the queue head when nothing is held.
    always_comb begin
        src_sel    = r_busy ? r_sel    : t_piece_sel'(i_job[SEL_BITS+CW-1:CW]);
        src_coords = r_busy ? r_coords : i_job[CW-1:0];
        src_index  = r_busy ? r_index  : '0;
        {bx0, by0, bx1, by1, hx0, hx1, row_lo, row_hi} = src_coords;
    end

    // Pick the first remaining strip in emission order.
    always_comb begin
        rem_sel = src_sel;
        px0 = bx0;
        py0 = by0;
        px1 = bx1;
        py1 = row_lo;
        priority if (src_sel.above) begin
            rem_sel.above = 1'b0;
        end else if (src_sel.below) begin
            rem_sel.below = 1'b0;
            py0 = row_hi;
            py1 = by1;
        end else if (src_sel.left) begin
            rem_sel.left = 1'b0;
            py0 = row_lo;
            px1 = hx0;
            py1 = row_hi;
        end else begin
            rem_sel.right = 1'b0;
            px0 = hx1;
            py0 = row_lo;
            py1 = row_hi;
        end
    end

    assign can_load = !r_out_valid || i_ready;
    assign fire     = can_load && (r_busy || !i_q_status.empty);
    assign o_pop    = fire && !r_busy;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_busy      <= (rem_sel != '0);
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_x0        <= px0;
            r_y0        <= py0;
            r_x1        <= px1;
            r_y1        <= py1;
            r_out_index <= src_index;
            r_out_last  <= (rem_sel == '0);
            r_sel       <= rem_sel;
            r_index     <= src_index + 1'b1;
            if (!r_busy) begin
                r_coords <= src_coords;
            end
        end
    end

    assign o_busy        = r_busy;
    assign o_valid       = r_out_valid;
    assign o_piece_x0    = r_x0;
    assign o_piece_y0    = r_y0;
    assign o_piece_x1    = r_x1;
    assign o_piece_y1    = r_y1;
    assign o_piece_index = r_out_index;
    assign o_last_piece  = r_out_last;

endmodule

// ===== rtl/rectangle_subtract_unit.sv =====
// ----------------------------------------------------------------------------
// Rectangle subtract unit
// Emits the non-overlapping pieces of a box that a hole leaves uncovered.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  input   | in        | i_valid / o_ready  | box and hole corners
//  output  | out       | o_valid / i_ready  | piece corners, index, last flag
//
//  An input item is classified in the cycle it is transferred and queued in a
//  two-entry job queue; its first piece then goes from the queue to the output register.
//  The back part emits one piece per cycle while the output is not stalled,
//  and an item gives one to four pieces; the emitter sets the sustained rate.
//  Items with no pieces are taken and dropped without output.
//  Reset clears the queue and the emitter; a stalled output holds its piece
//  while the queue keeps accepting items until it is full.
// ----------------------------------------------------------------------------
module rectangle_subtract_unit
    import rsub_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_box_x0,
    input  logic signed [COORD_BITS-1:0] i_box_y0,
    input  logic signed [COORD_BITS-1:0] i_box_x1,
    input  logic signed [COORD_BITS-1:0] i_box_y1,
    input  logic signed [COORD_BITS-1:0] i_hole_x0,
    input  logic signed [COORD_BITS-1:0] i_hole_y0,
    input  logic signed [COORD_BITS-1:0] i_hole_x1,
    input  logic signed [COORD_BITS-1:0] i_hole_y1,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS-1:0] o_piece_x0,
    output logic signed [COORD_BITS-1:0] o_piece_y0,
    output logic signed [COORD_BITS-1:0] o_piece_x1,
    output logic signed [COORD_BITS-1:0] o_piece_y1,
    output logic [INDEX_BITS-1:0]        o_piece_index,
    output logic                         o_last_piece
);

    localparam int JOB_BITS = SEL_BITS + JOB_COORDS * COORD_BITS;

    logic                q_push;
    logic                q_pop;
    logic [JOB_BITS-1:0] q_wr_job;
    logic [JOB_BITS-1:0] q_rd_job;
    t_queue_status       q_status;
    logic                back_busy;

    // Front part: classification.
    rsub_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_box_x0   (i_box_x0),
        .i_box_y0   (i_box_y0),
        .i_box_x1   (i_box_x1),
        .i_box_y1   (i_box_y1),
        .i_hole_x0  (i_hole_x0),
        .i_hole_y0  (i_hole_y0),
        .i_hole_x1  (i_hole_x1),
        .i_hole_y1  (i_hole_y1),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_job      (q_wr_job)
    );

    // Job queue between the two parts.
    rsub_queue #(
        .WIDTH (JOB_BITS),
        .DEPTH (2)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_wr_job),
        .i_pop    (q_pop),
        .o_data   (q_rd_job),
        .o_status (q_status)
    );

    // Back part: piece emission.
    rsub_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (q_status),
        .i_job         (q_rd_job),
        .o_pop         (q_pop),
        .o_busy        (back_busy),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_piece_x0    (o_piece_x0),
        .o_piece_y0    (o_piece_y0),
        .o_piece_x1    (o_piece_x1),
        .o_piece_y1    (o_piece_y1),
        .o_piece_index (o_piece_index),
        .o_last_piece  (o_last_piece)
    );

    // Every emitted piece covers at least one cell.
    a_piece_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_piece_x0 < o_piece_x1) && (o_piece_y0 < o_piece_y1))
        else $error("empty piece emitted");

    // A piece that is not the last one leaves a job held in the back part.
    a_more_pieces_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_piece |-> back_busy)
        else $error("non-final piece without a held job");

    // The queue is never popped when empty nor pushed when full.
    a_queue_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_status.empty) && !(q_push && q_status.full))
        else $error("job queue overrun or underrun");

    // After a final piece is taken, the next piece starts a new run.
    a_index_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last_piece ##1 o_valid |-> o_piece_index == '0)
        else $error("piece index did not restart");

endmodule
